// File: hdl/des_block_cipher_macros.svh
// Assertion macros used by the cipher controller.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef DES_BLOCK_CIPHER_MACROS_SVH
`define DES_BLOCK_CIPHER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DES_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("des_block_cipher: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DES_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("des_block_cipher: next-cycle check failed");

`endif

// File: hdl/des_pkg.sv
package des_pkg;

    localparam int unsigned ROUNDS_DEFAULT = 16;

    typedef struct packed {
        logic load;
        logic round;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic last_round;
    } t_dp_status;

    localparam int unsigned TAB_IP [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7 };

    localparam int unsigned TAB_FP [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25 };

    localparam int unsigned TAB_E [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
        28,29,30,31,32,1 };

    localparam int unsigned TAB_P [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25 };

    localparam int unsigned TAB_PC1 [56] = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
        10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
        63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4 };

    localparam int unsigned TAB_PC2 [48] = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53,
        46,42,50,36,29,32 };

    localparam int unsigned SHIFTS [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

    localparam int unsigned SBOX [8][4][16] = '{
        '{'{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7},'{0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8},
          '{4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0},'{15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13}},
        '{'{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10},'{3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5},
          '{0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15},'{13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9}},
        '{'{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8},'{13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1},
          '{13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7},'{1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12}},
        '{'{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15},'{13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9},
          '{10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4},'{3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14}},
        '{'{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9},'{14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6},
          '{4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14},'{11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3}},
        '{'{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11},'{10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8},
          '{9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6},'{4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13}},
        '{'{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1},'{13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6},
          '{1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2},'{6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12}},
        '{'{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7},'{1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2},
          '{7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8},'{2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}} };

    // Table bit 1 is the most significant bit of each field.
    function automatic logic [63:0] perm_ip(input logic [63:0] v);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-TAB_IP[i]];
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] v);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-TAB_FP[i]];
        return r;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] v);
        logic [55:0] r;
        r = '0;
        for (int i = 0; i < 56; i++) r[55-i] = v[64-TAB_PC1[i]];
        return r;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] v);
        logic [47:0] r;
        r = '0;
        for (int i = 0; i < 48; i++) r[47-i] = v[56-TAB_PC2[i]];
        return r;
    endfunction

    function automatic logic [27:0] rot_left(input logic [27:0] v, input int unsigned s);
        logic [55:0] t;
        t = {v, v} << s;
        return t[55:28];
    endfunction

    function automatic logic [27:0] rot_right(input logic [27:0] v, input int unsigned s);
        logic [55:0] t;
        t = {v, v} >> s;
        return t[27:0];
    endfunction

    // Total left rotation of C and D after the first n rounds of the schedule.
    function automatic int unsigned shift_total(input int unsigned n);
        int unsigned sum;
        sum = 0;
        for (int i = 0; i < 16; i++) begin
            if (i < n) sum += SHIFTS[i];
        end
        return sum;
    endfunction

    // Round function: expansion, key mix, S-boxes and P permutation.
    function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] e;
        logic [31:0] s;
        logic [31:0] p;
        logic [5:0]  six;
        e = '0;
        s = '0;
        p = '0;
        six = '0;
        for (int i = 0; i < 48; i++) e[47-i] = r[32-TAB_E[i]];
        e = e ^ k;
        for (int i = 0; i < 8; i++) begin
            six = e[47-6*i -: 6];
            s[31-4*i -: 4] = 4'(SBOX[i][{six[5], six[0]}][six[4:1]]);
        end
        for (int i = 0; i < 32; i++) p[31-i] = s[32-TAB_P[i]];
        return p;
    endfunction

endpackage

// File: hdl/des_ctrl.sv
`include "des_block_cipher_macros.svh"

module des_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    output logic                  o_valid,
    input  logic                  i_stall,
    input  des_pkg::t_dp_status   i_status,
    output des_pkg::t_dp_cmd      o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ROUND  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;
    logic       in_ready;
    logic       accept;

    // The output register can take a new beat when empty or when its beat leaves now.
    assign out_free = !r_out_valid || !i_stall;
    assign in_ready = (r_state == ST_IDLE) || ((r_state == ST_FINISH) && out_free);
    assign accept   = i_valid && in_ready;
    assign o_stall  = !in_ready;
    assign o_valid  = r_out_valid;

    assign o_cmd.load     = accept;
    assign o_cmd.round    = (r_state == ST_ROUND);
    assign o_cmd.out_load = (r_state == ST_FINISH) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_ROUND;
            end
            ST_ROUND: begin
                if (i_status.last_round) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) n_state = accept ? ST_ROUND : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `DES_ASSERT_NEXT(a_accept_starts_rounds, accept, r_state == ST_ROUND)
    `DES_ASSERT_NEXT(a_last_round_finishes, (r_state == ST_ROUND) && i_status.last_round, r_state == ST_FINISH)
    `DES_ASSERT_NEXT(a_result_shown, o_cmd.out_load, r_out_valid)
    `DES_ASSERT_SAME(a_busy_stalls_input, r_state == ST_ROUND, o_stall)

endmodule

// File: hdl/des_datapath.sv
module des_datapath #(
    parameter int unsigned ROUNDS = des_pkg::ROUNDS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [63:0]           i_cfg_wr_data,
    input  logic                  i_op,
    input  logic [63:0]           i_data_in,
    input  des_pkg::t_dp_cmd      i_cmd,
    output des_pkg::t_dp_status   o_status,
    output logic [63:0]           o_data_out
);

    localparam int unsigned RW      = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam logic [3:0]  LAST    = 4'(ROUNDS - 1);
    // Decryption starts from the C and D halves as they stand after the last round.
    localparam int unsigned DEC_ROT = des_pkg::shift_total(ROUNDS) % 28;

    logic [63:0]   r_key;
    logic          r_dec;
    logic [31:0]   r_left;
    logic [31:0]   r_right;
    logic [55:0]   r_cd;
    logic [RW-1:0] r_round;
    logic [63:0]   r_data_out;

    logic [63:0] ip_blk;
    logic [55:0] pc1_cd;
    logic [55:0] n_cd_start;
    logic [3:0]  enc_idx;
    logic [3:0]  dec_idx;
    logic [27:0] c_cur;
    logic [27:0] d_cur;
    logic [27:0] c_left;
    logic [27:0] d_left;
    logic [27:0] c_right;
    logic [27:0] d_right;
    logic [55:0] cd_key;
    logic [55:0] n_cd;
    logic [47:0] sub_key;
    logic [31:0] n_right;

    assign ip_blk = des_pkg::perm_ip(i_data_in);
    assign pc1_cd = des_pkg::perm_pc1(r_key);
    assign n_cd_start = i_op ? {des_pkg::rot_left(pc1_cd[55:28], DEC_ROT),
                                des_pkg::rot_left(pc1_cd[27:0], DEC_ROT)} : pc1_cd;

    assign enc_idx = 4'(r_round);
    assign dec_idx = LAST - 4'(r_round);
    assign c_cur   = r_cd[55:28];
    assign d_cur   = r_cd[27:0];

    assign c_left  = (des_pkg::SHIFTS[enc_idx] == 2) ? des_pkg::rot_left(c_cur, 2)
                                                     : des_pkg::rot_left(c_cur, 1);
    assign d_left  = (des_pkg::SHIFTS[enc_idx] == 2) ? des_pkg::rot_left(d_cur, 2)
                                                     : des_pkg::rot_left(d_cur, 1);
    assign c_right = (des_pkg::SHIFTS[dec_idx] == 2) ? des_pkg::rot_right(c_cur, 2)
                                                     : des_pkg::rot_right(c_cur, 1);
    assign d_right = (des_pkg::SHIFTS[dec_idx] == 2) ? des_pkg::rot_right(d_cur, 2)
                                                     : des_pkg::rot_right(d_cur, 1);

    // Encryption rotates before taking the key; decryption takes the key, then undoes the rotation.
    assign cd_key    = r_dec ? r_cd : {c_left, d_left};
    assign n_cd      = r_dec ? {c_right, d_right} : {c_left, d_left};
    assign sub_key   = des_pkg::perm_pc2(cd_key);
    assign n_right   = r_left ^ des_pkg::feistel(r_right, sub_key);

    assign o_status.last_round = (r_round == RW'(ROUNDS - 1));
    assign o_data_out          = r_data_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_round <= '0;
        end else begin
            if (i_cfg_wr_en) r_key <= i_cfg_wr_data;
            if (i_cmd.load) begin
                r_round <= '0;
            end else if (i_cmd.round && !o_status.last_round) begin
                r_round <= r_round + RW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dec   <= i_op;
            r_left  <= ip_blk[63:32];
            r_right <= ip_blk[31:0];
            r_cd    <= n_cd_start;
        end else if (i_cmd.round) begin
            r_left  <= r_right;
            r_right <= n_right;
            r_cd    <= n_cd;
        end
        if (i_cmd.out_load) r_data_out <= des_pkg::perm_fp({r_right, r_left});
    end

endmodule

// File: hdl/des_block_cipher.sv
// DES block cipher, one 64-bit block per input beat.
// The key is written through i_cfg_wr_en / i_cfg_wr_data and must only be changed while
// the block is idle. It resets to zero.
// Input channel: i_valid, o_stall, i_op (0 encrypt, 1 decrypt) and i_data_in. A beat is
// taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid, i_stall and o_data_out, one result beat for every input beat.
// Each block is processed one Feistel round at a time, then the final permutation is applied
// into the output register. A new block is taken only once the current one has finished its
// rounds, as a single round unit is shared by all rounds; the round keys are rotated along
// with it.
// While a result waits in the output register the next block is taken and processed. Should
// the receiver still stall when that block finishes, it is held and o_stall stays high until
// the output register frees.
// Reset is synchronous and active low; it empties the block and clears the key.
module des_block_cipher #(
    parameter int unsigned ROUNDS = des_pkg::ROUNDS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [63:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [63:0] i_data_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_data_out
);

    // Commands from the controller and status back from the datapath.
    des_pkg::t_dp_cmd    dp_cmd;
    des_pkg::t_dp_status dp_status;

    des_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    des_datapath #(
        .ROUNDS (ROUNDS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_op          (i_op),
        .i_data_in     (i_data_in),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .o_data_out    (o_data_out)
    );

endmodule
